// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the sequencer RTL of the scatter interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define CSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define CSI_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/csi_pkg.sv =====
// Shared types and constants of the complex scatter interpolator.
`default_nettype none
package csi_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 15;
    localparam int ACC_W    = 24;
    localparam int CELL_W   = 2 * ACC_W;
    localparam int PROD_W   = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] REG_TAP_ROWS   = 2'd0;
    localparam logic [1:0] REG_TAP_COLS   = 2'd1;
    localparam logic [1:0] REG_FRAME_ROWS = 2'd2;
    localparam logic [1:0] REG_ROW_LENGTH = 2'd3;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_COPY = 2'd1;
    localparam logic [1:0] KIND_ZERO = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } t_pipe_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/complex_2d_scatter_interpolator.sv =====
// Top level of the complex 2-D scatter interpolator: config port, memories, output stage.
//
// Usage. Items arrive on the s_axis stream; tuser carries the operation (load tap,
// add sample, frame reset, read cell) and tdata the operand fields. Only a read
// returns a transfer on m_axis. Registers tap_rows, tap_cols, frame_rows and
// row_length sit on the APB port at byte addresses 0, 4, 8 and 12.
// Work per item, set by the grid accumulator RAM's one read port (one cell a cycle):
//   load tap      written to the tap RAM as the item is taken
//   add sample    tap_rows * tap_cols taps, one read-modify-write per tap that lands
//                 in the grid, through the multiply pipe stages s1 and s2
//   frame reset   sweeps (tap_rows + frame_rows) * MAX_ROW_LENGTH cells, copy then clear
//   read cell     one grid RAM read, then a load into the m_axis output register
// Items are taken one at a time; s_axis_tready drops while an item is in work.
// After reset the grid is cleared in a sweep of (MAX_TAP_ROWS + MAX_FRAME_ROWS)
// * MAX_ROW_LENGTH cells (2560 at defaults); s_axis_tready stays low for the sweep
// and until the s1 and s2 stages drain. APB writes are taken meanwhile. A stalled
// m_axis holds its result, and a read then waits for the output register before
// it finishes.
`default_nettype none
module complex_2d_scatter_interpolator #(
    parameter int MAX_TAP_ROWS   = 4,
    parameter int MAX_TAP_COLS   = 8,
    parameter int MAX_FRAME_ROWS = 16,
    parameter int MAX_ROW_LENGTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] sample_real, [31:16] sample_imag, [36:32] time_index,
    // [43:37] freq_index, [45:44] tap_row, [48:46] tap_col, [63:49] tap_value
    input  wire logic [63:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [23:0] cell_real, [47:24] cell_imag
    output logic [47:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import csi_pkg::*;

    localparam int GROWS  = MAX_TAP_ROWS + MAX_FRAME_ROWS;
    localparam int TDEPTH = MAX_TAP_ROWS * MAX_TAP_COLS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int GRW    = $clog2(GROWS);
    localparam int CW     = $clog2(MAX_ROW_LENGTH);
    localparam int GAW    = GRW + CW;
    localparam int GDEPTH = GROWS * (1 << CW);

    logic [2:0]  r_tap_rows;
    logic [3:0]  r_tap_cols;
    logic [4:0]  r_frame_rows;
    logic [7:0]  r_row_length;
    logic        r_out_valid;
    logic [47:0] r_out_data;

    logic                 w_cfg_wr;
    logic                 w_out_free;
    logic                 w_res_load;
    logic                 w_res_hit;
    logic                 w_tap_wr_en;
    logic [TAW-1:0]       w_tap_wr_addr;
    logic [TAP_W-1:0]     w_tap_wr_data;
    logic                 w_tap_rd_en;
    logic [TAW-1:0]       w_tap_rd_addr;
    logic [TAP_W-1:0]     w_tap_rd_data;
    logic                 w_grid_rd_en;
    logic [GAW-1:0]       w_grid_rd_addr;
    logic [CELL_W-1:0]    w_grid_rd_data;
    logic                 w_grid_wr_en;
    logic [GAW-1:0]       w_grid_wr_addr;
    logic [CELL_W-1:0]    w_grid_wr_data;
    t_pipe_ctl            w_s1_ctl;
    logic [GAW-1:0]       w_s1_addr;
    logic signed [SAMPLE_W-1:0] w_xr;
    logic signed [SAMPLE_W-1:0] w_xi;
    logic                 w_s2_busy;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_rows   <= 3'd4;
            r_tap_cols   <= 4'd8;
            r_frame_rows <= 5'd16;
            r_row_length <= 8'd128;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_TAP_ROWS:   r_tap_rows   <= pwdata[2:0];
                REG_TAP_COLS:   r_tap_cols   <= pwdata[3:0];
                REG_FRAME_ROWS: r_frame_rows <= pwdata[4:0];
                REG_ROW_LENGTH: r_row_length <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TAP_ROWS:   prdata = 32'(r_tap_rows);
            REG_TAP_COLS:   prdata = 32'(r_tap_cols);
            REG_FRAME_ROWS: prdata = 32'(r_frame_rows);
            REG_ROW_LENGTH: prdata = 32'(r_row_length);
        endcase
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    csi_seq #(
        .MAX_TAP_ROWS   (MAX_TAP_ROWS),
        .MAX_TAP_COLS   (MAX_TAP_COLS),
        .MAX_FRAME_ROWS (MAX_FRAME_ROWS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tap_rows     (r_tap_rows),
        .i_tap_cols     (r_tap_cols),
        .i_frame_rows   (r_frame_rows),
        .i_row_length   (r_row_length),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_op           (s_axis_tuser),
        .i_sample_real  (s_axis_tdata[15:0]),
        .i_sample_imag  (s_axis_tdata[31:16]),
        .i_time_index   (s_axis_tdata[36:32]),
        .i_freq_index   (s_axis_tdata[43:37]),
        .i_tap_row      (s_axis_tdata[45:44]),
        .i_tap_col      (s_axis_tdata[48:46]),
        .i_tap_value    (s_axis_tdata[63:49]),
        .i_out_free     (w_out_free),
        .o_res_load     (w_res_load),
        .o_res_hit      (w_res_hit),
        .o_tap_wr_en    (w_tap_wr_en),
        .o_tap_wr_addr  (w_tap_wr_addr),
        .o_tap_wr_data  (w_tap_wr_data),
        .o_tap_rd_en    (w_tap_rd_en),
        .o_tap_rd_addr  (w_tap_rd_addr),
        .o_grid_rd_en   (w_grid_rd_en),
        .o_grid_rd_addr (w_grid_rd_addr),
        .o_s1_ctl       (w_s1_ctl),
        .o_s1_addr      (w_s1_addr),
        .o_xr           (w_xr),
        .o_xi           (w_xi),
        .i_s2_busy      (w_s2_busy),
        .i_wr_en        (w_grid_wr_en),
        .i_wr_addr      (w_grid_wr_addr)
    );

    csi_ram #(
        .DEPTH (TDEPTH),
        .WIDTH (TAP_W)
    ) u_tap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_tap_wr_en),
        .i_wr_addr (w_tap_wr_addr),
        .i_wr_data (w_tap_wr_data),
        .i_rd_en   (w_tap_rd_en),
        .i_rd_addr (w_tap_rd_addr),
        .o_rd_data (w_tap_rd_data)
    );

    csi_ram #(
        .DEPTH (GDEPTH),
        .WIDTH (CELL_W)
    ) u_grid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_grid_wr_en),
        .i_wr_addr (w_grid_wr_addr),
        .i_wr_data (w_grid_wr_data),
        .i_rd_en   (w_grid_rd_en),
        .i_rd_addr (w_grid_rd_addr),
        .o_rd_data (w_grid_rd_data)
    );

    csi_mac #(
        .GAW (GAW)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_s1_ctl),
        .i_addr    (w_s1_addr),
        .i_xr      (w_xr),
        .i_xi      (w_xi),
        .i_tap     (w_tap_rd_data),
        .i_cell    (w_grid_rd_data),
        .o_wr_en   (w_grid_wr_en),
        .o_wr_addr (w_grid_wr_addr),
        .o_wr_data (w_grid_wr_data),
        .o_busy    (w_s2_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_data <= w_res_hit ? w_grid_rd_data : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// ===== hw/rtl/csi_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module csi_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 15,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== hw/rtl/csi_mac.sv =====
// Multiply, round and saturating accumulate stages of the grid update pipe; also writes copied and zeroed cells.
`default_nettype none
module csi_mac #(
    parameter int GAW = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire csi_pkg::t_pipe_ctl               i_ctl,
    input  wire logic [GAW-1:0]                   i_addr,
    input  wire logic signed [csi_pkg::SAMPLE_W-1:0] i_xr,
    input  wire logic signed [csi_pkg::SAMPLE_W-1:0] i_xi,
    input  wire logic [csi_pkg::TAP_W-1:0]        i_tap,
    input  wire logic [csi_pkg::CELL_W-1:0]       i_cell,
    output logic                                  o_wr_en,
    output logic [GAW-1:0]                        o_wr_addr,
    output logic [csi_pkg::CELL_W-1:0]            o_wr_data,
    output logic                                  o_busy
);
    import csi_pkg::*;

    localparam int SUM_W = ACC_W + 1;
    localparam int D_W   = PROD_W - 15;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 32'sd16384;
    localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    t_pipe_ctl                 r_s2_ctl;
    logic [GAW-1:0]            r_s2_addr;
    logic [CELL_W-1:0]         r_cell;
    logic signed [PROD_W-1:0]  r_p_re;
    logic signed [PROD_W-1:0]  r_p_im;

    logic signed [PROD_W-1:0]  w_xr_e;
    logic signed [PROD_W-1:0]  w_xi_e;
    logic signed [PROD_W-1:0]  w_tap_e;
    logic signed [ACC_W-1:0]   w_sum_re;
    logic signed [ACC_W-1:0]   w_sum_im;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [D_W-1:0]   d
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(d);
        if (s[SUM_W-1] != s[SUM_W-2]) begin
            sat_add = s[SUM_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    assign w_xr_e  = PROD_W'(i_xr);
    assign w_xi_e  = PROD_W'(i_xi);
    assign w_tap_e = PROD_W'(i_tap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '{valid: 1'b0, kind: KIND_ZERO};
        end else begin
            r_s2_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_addr <= i_addr;
        r_cell    <= i_cell;
        r_p_re    <= w_xr_e * w_tap_e + ROUND_BIAS;
        r_p_im    <= w_xi_e * w_tap_e + ROUND_BIAS;
    end

    assign w_sum_re = sat_add(r_cell[ACC_W-1:0], r_p_re[PROD_W-1:15]);
    assign w_sum_im = sat_add(r_cell[CELL_W-1:ACC_W], r_p_im[PROD_W-1:15]);

    always_comb begin
        case (r_s2_ctl.kind)
            KIND_ADD:  o_wr_data = {w_sum_im, w_sum_re};
            KIND_COPY: o_wr_data = r_cell;
            default:   o_wr_data = '0;
        endcase
    end

    assign o_wr_en   = r_s2_ctl.valid;
    assign o_wr_addr = r_s2_addr;
    assign o_busy    = r_s2_ctl.valid;

endmodule
`default_nettype wire

// ===== hw/rtl/csi_seq.sv =====
// Operation sequencer: decodes items and walks the tap, copy and clear sweeps.
`default_nettype none
`include "assert_macros.svh"
module csi_seq #(
    parameter int MAX_TAP_ROWS   = 4,
    parameter int MAX_TAP_COLS   = 8,
    parameter int MAX_FRAME_ROWS = 16,
    parameter int MAX_ROW_LENGTH = 128,
    localparam int GROWS = MAX_TAP_ROWS + MAX_FRAME_ROWS,
    localparam int TDEPTH = MAX_TAP_ROWS * MAX_TAP_COLS,
    localparam int TAW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1,
    localparam int GRW = $clog2(GROWS),
    localparam int CW = $clog2(MAX_ROW_LENGTH),
    localparam int GAW = GRW + CW
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [2:0]                           i_tap_rows,
    input  wire logic [3:0]                           i_tap_cols,
    input  wire logic [4:0]                           i_frame_rows,
    input  wire logic [7:0]                           i_row_length,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_op,
    input  wire logic signed [csi_pkg::SAMPLE_W-1:0]  i_sample_real,
    input  wire logic signed [csi_pkg::SAMPLE_W-1:0]  i_sample_imag,
    input  wire logic [4:0]                           i_time_index,
    input  wire logic [6:0]                           i_freq_index,
    input  wire logic [1:0]                           i_tap_row,
    input  wire logic [2:0]                           i_tap_col,
    input  wire logic [csi_pkg::TAP_W-1:0]            i_tap_value,
    input  wire logic                                 i_out_free,
    output logic                                      o_res_load,
    output logic                                      o_res_hit,
    output logic                                      o_tap_wr_en,
    output logic [TAW-1:0]                            o_tap_wr_addr,
    output logic [csi_pkg::TAP_W-1:0]                 o_tap_wr_data,
    output logic                                      o_tap_rd_en,
    output logic [TAW-1:0]                            o_tap_rd_addr,
    output logic                                      o_grid_rd_en,
    output logic [GAW-1:0]                            o_grid_rd_addr,
    output csi_pkg::t_pipe_ctl                        o_s1_ctl,
    output logic [GAW-1:0]                            o_s1_addr,
    output logic signed [csi_pkg::SAMPLE_W-1:0]       o_xr,
    output logic signed [csi_pkg::SAMPLE_W-1:0]       o_xi,
    input  wire logic                                 i_s2_busy,
    input  wire logic                                 i_wr_en,
    input  wire logic [GAW-1:0]                       i_wr_addr
);
    import csi_pkg::*;

    localparam int TRW = (MAX_TAP_ROWS > 1) ? $clog2(MAX_TAP_ROWS) : 1;
    localparam int TCW = (MAX_TAP_COLS > 1) ? $clog2(MAX_TAP_COLS) : 1;
    localparam int NTW = $clog2(MAX_TAP_ROWS + 1);
    localparam int NCW = $clog2(MAX_TAP_COLS + 1);
    localparam int NFW = $clog2(MAX_FRAME_ROWS + 1);
    localparam int NRW = $clog2(GROWS + 1);
    localparam int NLW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int RSW = ((GRW > 5) ? GRW : 5) + 1;
    localparam int CAW = ((CW > 7) ? CW : 7) + 2;
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_ROW_LENGTH - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD    = 3'd1;
    localparam logic [2:0] ST_COPY   = 3'd2;
    localparam logic [2:0] ST_CLEAR  = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [TRW-1:0]              r_i, n_i;
    logic [TCW-1:0]              r_j, n_j;
    logic [GRW-1:0]              r_row, n_row;
    logic [CW-1:0]               r_col, n_col;
    logic [NRW-1:0]              r_clr_end, n_clr_end;
    logic [NCW-1:0]              r_half, n_half;
    logic [4:0]                  r_t0, n_t0;
    logic [6:0]                  r_f0, n_f0;
    logic signed [SAMPLE_W-1:0]  r_xr, n_xr;
    logic signed [SAMPLE_W-1:0]  r_xi, n_xi;
    logic                        r_rd_hit, n_rd_hit;
    t_pipe_ctl                   r_s1_ctl, n_s1_ctl;
    logic [GAW-1:0]              r_s1_addr, n_s1_addr;

    logic [NTW-1:0]  w_nt;
    logic [NCW-1:0]  w_nf;
    logic [NFW-1:0]  w_nfr;
    logic [NLW-1:0]  w_nl;
    logic [NRW-1:0]  w_rows;
    logic            w_accept;
    logic [RSW-1:0]  w_add_row;
    logic [CAW-1:0]  w_add_col;
    logic            w_add_hit;
    logic [GAW-1:0]  w_add_addr;
    logic [GRW-1:0]  w_src_row;
    logic            w_rd_hit;

    assign w_nt  = (i_tap_rows > MAX_TAP_ROWS) ? NTW'(MAX_TAP_ROWS) : NTW'(i_tap_rows);
    assign w_nf  = (i_tap_cols > MAX_TAP_COLS) ? NCW'(MAX_TAP_COLS) : NCW'(i_tap_cols);
    assign w_nfr = (i_frame_rows > MAX_FRAME_ROWS) ? NFW'(MAX_FRAME_ROWS)
                                                   : NFW'(i_frame_rows);
    assign w_nl  = (i_row_length > MAX_ROW_LENGTH) ? NLW'(MAX_ROW_LENGTH)
                                                   : NLW'(i_row_length);
    assign w_rows = NRW'(w_nt) + NRW'(w_nfr);

    assign o_in_ready = (r_state == ST_IDLE) && !r_s1_ctl.valid && !i_s2_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    // tap (i, j) lands at row t0 + i, column f0 + j - tap_cols/2
    assign w_add_row  = RSW'(r_t0) + RSW'(r_i);
    assign w_add_col  = CAW'(r_f0) + CAW'(r_j) - CAW'(r_half);
    assign w_add_hit  = (w_add_row < RSW'(w_rows)) && !w_add_col[CAW-1]
                        && (w_add_col < CAW'(w_nl));
    assign w_add_addr = {w_add_row[GRW-1:0], w_add_col[CW-1:0]};
    assign w_src_row  = GRW'(w_nfr) + r_row;
    assign w_rd_hit   = (i_time_index < w_rows) && (i_freq_index < w_nl);

    assign o_tap_wr_addr = TAW'(TAW'(i_tap_row) * TAW'(MAX_TAP_COLS) + TAW'(i_tap_col));
    assign o_tap_wr_data = i_tap_value;
    assign o_tap_rd_addr = TAW'(TAW'(r_i) * TAW'(MAX_TAP_COLS) + TAW'(r_j));

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_row       = r_row;
        n_col       = r_col;
        n_clr_end   = r_clr_end;
        n_half      = r_half;
        n_t0        = r_t0;
        n_f0        = r_f0;
        n_xr        = r_xr;
        n_xi        = r_xi;
        n_rd_hit    = r_rd_hit;
        n_s1_ctl    = '{valid: 1'b0, kind: KIND_ZERO};
        n_s1_addr   = r_s1_addr;
        o_tap_wr_en = 1'b0;
        o_tap_rd_en = 1'b0;
        o_grid_rd_en   = 1'b0;
        o_grid_rd_addr = w_add_addr;
        o_res_load  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_op)
                        OP_LOAD: begin
                            o_tap_wr_en = (i_tap_row < MAX_TAP_ROWS)
                                          && (i_tap_col < MAX_TAP_COLS);
                        end
                        OP_ADD: begin
                            n_i    = '0;
                            n_j    = '0;
                            n_half = w_nf >> 1;
                            n_t0   = i_time_index;
                            n_f0   = i_freq_index;
                            n_xr   = i_sample_real;
                            n_xi   = i_sample_imag;
                            if (w_nt != '0 && w_nf != '0) begin
                                n_state = ST_ADD;
                            end
                        end
                        OP_FRAME: begin
                            n_col     = '0;
                            n_clr_end = w_rows;
                            if (w_nt != '0) begin
                                n_state = ST_COPY;
                                n_row   = '0;
                            end else if (w_nfr != '0) begin
                                n_state = ST_CLEAR;
                                n_row   = GRW'(w_nt);
                            end
                        end
                        OP_READ: begin
                            o_grid_rd_en   = w_rd_hit;
                            o_grid_rd_addr = {GRW'(i_time_index), CW'(i_freq_index)};
                            n_rd_hit       = w_rd_hit;
                            n_state        = ST_RDWAIT;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                o_tap_rd_en  = 1'b1;
                o_grid_rd_en = w_add_hit;
                n_s1_ctl     = '{valid: w_add_hit, kind: KIND_ADD};
                n_s1_addr    = w_add_addr;
                if (NCW'(r_j) + NCW'(1) == w_nf) begin
                    n_j = '0;
                    if (NTW'(r_i) + NTW'(1) == w_nt) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + TRW'(1);
                    end
                end else begin
                    n_j = r_j + TCW'(1);
                end
            end
            ST_COPY: begin
                o_grid_rd_en   = 1'b1;
                o_grid_rd_addr = {w_src_row, r_col};
                n_s1_ctl       = '{valid: 1'b1, kind: KIND_COPY};
                n_s1_addr      = {r_row, r_col};
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    if (NTW'(r_row) + NTW'(1) == w_nt) begin
                        if (w_nfr != '0) begin
                            n_state = ST_CLEAR;
                            n_row   = GRW'(w_nt);
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_row = r_row + GRW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            ST_CLEAR: begin
                n_s1_ctl  = '{valid: 1'b1, kind: KIND_ZERO};
                n_s1_addr = {r_row, r_col};
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    if (NRW'(r_row) + NRW'(1) == r_clr_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + GRW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            ST_RDWAIT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // reset starts a clearing sweep over the whole grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_i       <= '0;
            r_j       <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_clr_end <= NRW'(GROWS);
            r_rd_hit  <= 1'b0;
            r_s1_ctl  <= '{valid: 1'b0, kind: KIND_ZERO};
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_row     <= n_row;
            r_col     <= n_col;
            r_clr_end <= n_clr_end;
            r_rd_hit  <= n_rd_hit;
            r_s1_ctl  <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_half    <= n_half;
        r_t0      <= n_t0;
        r_f0      <= n_f0;
        r_xr      <= n_xr;
        r_xi      <= n_xi;
        r_s1_addr <= n_s1_addr;
    end

    assign o_res_hit = r_rd_hit;
    assign o_s1_ctl  = r_s1_ctl;
    assign o_s1_addr = r_s1_addr;
    assign o_xr      = r_xr;
    assign o_xi      = r_xi;

    `CSI_ASSERT_IMPL(a_no_rw_collide, i_clk, i_rst_n, o_grid_rd_en && i_wr_en, o_grid_rd_addr != i_wr_addr)
    `CSI_ASSERT_IMPL(a_add_in_extent, i_clk, i_rst_n, r_s1_ctl.valid && r_s1_ctl.kind == KIND_ADD, NRW'(r_s1_addr[GAW-1:CW]) < w_rows)
    `CSI_ASSERT_IMPL(a_clear_bound, i_clk, i_rst_n, r_state == ST_CLEAR, NRW'(r_row) < r_clr_end)
    `CSI_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, o_res_load, r_state == ST_IDLE && !r_s1_ctl.valid)

endmodule
`default_nettype wire

// ===== test/complex_2d_scatter_interpolator_test.sv =====
// Self-checking testbench for the complex 2-D scatter interpolator, with scoreboard.
module complex_2d_scatter_interpolator_test;
    import csi_pkg::*;

    localparam int N_TAP_ROWS   = 4;
    localparam int N_TAP_COLS   = 8;
    localparam int N_FRAME_ROWS = 16;
    localparam int N_ROW_LEN    = 128;
    localparam int N_GRID_ROWS  = N_TAP_ROWS + N_FRAME_ROWS;
    localparam int ACC_MAX      = 8388607;
    localparam int ACC_MIN      = -8388608;
    localparam int DRAIN_CYCLES = N_GRID_ROWS * N_ROW_LEN + 64;

    // low 64 bits follow the tdata layout, op rides on tuser
    typedef struct packed {
        logic [1:0]          op;
        logic [TAP_W-1:0]    tap_value;
        logic [2:0]          tap_col;
        logic [1:0]          tap_row;
        logic [6:0]          freq_index;
        logic [4:0]          time_index;
        logic signed [15:0]  sample_imag;
        logic signed [15:0]  sample_real;
    } t_stream_item;

    typedef struct {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } t_cell;

    class t_grid_scoreboard;
        logic [TAP_W-1:0] taps [N_TAP_ROWS][N_TAP_COLS];
        int               acc_re [N_GRID_ROWS * N_ROW_LEN];
        int               acc_im [N_GRID_ROWS * N_ROW_LEN];
        logic [2:0]       tap_rows   = 3'd4;
        logic [3:0]       tap_cols   = 4'd8;
        logic [4:0]       frame_rows = 5'd16;
        logic [7:0]       row_length = 8'd128;
        t_cell            pending_cells [$];
        int               errors, n_loads, n_adds, n_frames, n_reads, n_sat;

        function int clamp_to(int v, int hi);
            return v > hi ? hi : v;
        endfunction

        function int rows_in_use();
            return clamp_to(tap_rows, N_TAP_ROWS) + clamp_to(frame_rows, N_FRAME_ROWS);
        endfunction

        function int cols_in_use();
            return clamp_to(row_length, N_ROW_LEN);
        endfunction

        function longint round_q15(longint p);
            return (p + 64'sd16384) >>> 15;
        endfunction

        function int sat_add(int acc, longint d);
            longint s;
            s = longint'(acc) + d;
            if (s > ACC_MAX) return ACC_MAX;
            if (s < ACC_MIN) return ACC_MIN;
            return int'(s);
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_TAP_ROWS:   tap_rows   = v[2:0];
                REG_TAP_COLS:   tap_cols   = v[3:0];
                REG_FRAME_ROWS: frame_rows = v[4:0];
                REG_ROW_LENGTH: row_length = v[7:0];
                default: ;
            endcase
        endfunction

        function void scatter(t_stream_item it);
            int nt, nf, rows, cols, r, c, k, w, xr, xi;
            nt   = clamp_to(tap_rows, N_TAP_ROWS);
            nf   = clamp_to(tap_cols, N_TAP_COLS);
            rows = rows_in_use();
            cols = cols_in_use();
            xr   = $signed(it.sample_real);
            xi   = $signed(it.sample_imag);
            for (int i = 0; i < nt; i++) begin
                r = int'(it.time_index) + i;
                if (r >= rows) continue;
                for (int j = 0; j < nf; j++) begin
                    c = int'(it.freq_index) + j - nf / 2;
                    if (c < 0 || c >= cols) continue;
                    w = taps[i][j];
                    k = r * N_ROW_LEN + c;
                    acc_re[k] = sat_add(acc_re[k], round_q15(longint'(xr) * w));
                    acc_im[k] = sat_add(acc_im[k], round_q15(longint'(xi) * w));
                end
            end
        endfunction

        function void shift_frame();
            int nt, nfr;
            nt  = clamp_to(tap_rows, N_TAP_ROWS);
            nfr = clamp_to(frame_rows, N_FRAME_ROWS);
            for (int i = 0; i < nt; i++)
                for (int c = 0; c < N_ROW_LEN; c++) begin
                    acc_re[i * N_ROW_LEN + c] = acc_re[(nfr + i) * N_ROW_LEN + c];
                    acc_im[i * N_ROW_LEN + c] = acc_im[(nfr + i) * N_ROW_LEN + c];
                end
            for (int i = nt; i < nt + nfr; i++)
                for (int c = 0; c < N_ROW_LEN; c++) begin
                    acc_re[i * N_ROW_LEN + c] = 0;
                    acc_im[i * N_ROW_LEN + c] = 0;
                end
        endfunction

        function void take_item(t_stream_item it);
            t_cell want;
            int    k;
            case (it.op)
                OP_LOAD: begin
                    taps[it.tap_row][it.tap_col] = it.tap_value;
                    n_loads++;
                end
                OP_ADD: begin
                    scatter(it);
                    n_adds++;
                end
                OP_FRAME: begin
                    shift_frame();
                    n_frames++;
                end
                default: begin
                    want.re = '0;
                    want.im = '0;
                    if (it.time_index < rows_in_use() && it.freq_index < cols_in_use()) begin
                        k = it.time_index * N_ROW_LEN + it.freq_index;
                        want.re = ACC_W'(acc_re[k]);
                        want.im = ACC_W'(acc_im[k]);
                        if (acc_re[k] == ACC_MAX || acc_re[k] == ACC_MIN ||
                            acc_im[k] == ACC_MAX || acc_im[k] == ACC_MIN)
                            n_sat++;
                    end
                    pending_cells.push_back(want);
                    n_reads++;
                end
            endcase
        endfunction

        function void check_cell(logic [CELL_W-1:0] d);
            t_cell want;
            if (pending_cells.size() == 0) begin
                $error("result transfer with no read outstanding: %h", d);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            if ($signed(d[ACC_W-1:0]) != want.re) begin
                $error("cell_real mismatch: expected %0d, got %0d",
                       want.re, $signed(d[ACC_W-1:0]));
                errors++;
            end
            if ($signed(d[CELL_W-1:ACC_W]) != want.im) begin
                $error("cell_imag mismatch: expected %0d, got %0d",
                       want.im, $signed(d[CELL_W-1:ACC_W]));
                errors++;
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata  = '0;
    logic [1:0]        s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [3:0]        paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;

    bit                feed_steady;
    bit                sink_steady;
    t_grid_scoreboard  sb = new();

    complex_2d_scatter_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready)
                sb.set_register(paddr[3:2], pwdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_item(t_stream_item'({s_axis_tuser, s_axis_tdata}));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_cell(m_axis_tdata);
        end
    end

    // mostly short stalls, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    initial begin
        forever begin
            @(posedge i_clk);
            if (!sink_steady && $urandom_range(0, 9) < 3) begin
                m_axis_tready <= 1'b0;
                repeat (idle_span()) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper bits carry junk; only the field bits count
    task automatic configure(input int tr, input int tc, input int fr, input int rl);
        apb_write(REG_TAP_ROWS,   32'(tr) | ($urandom << 8));
        apb_write(REG_TAP_COLS,   32'(tc) | ($urandom << 8));
        apb_write(REG_FRAME_ROWS, 32'(fr) | ($urandom << 8));
        apb_write(REG_ROW_LENGTH, 32'(rl) | ($urandom << 8));
    endtask

    task automatic send_item(input t_stream_item it);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= it[63:0];
        do @(posedge i_clk); while (!s_axis_tready);
        if (!feed_steady && $urandom_range(0, 9) < 3) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle_span()) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_stream_item make_item(input logic [1:0] op, input int re, input int im,
                                               input int t, input int f, input int trow,
                                               input int tcol, input int tval);
        t_stream_item it;
        it.op          = op;
        it.sample_real = 16'(re);
        it.sample_imag = 16'(im);
        it.time_index  = 5'(t);
        it.freq_index  = 7'(f);
        it.tap_row     = 2'(trow);
        it.tap_col     = 3'(tcol);
        it.tap_value   = TAP_W'(tval);
        return it;
    endfunction

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 19))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_stream_item random_item();
        t_stream_item it;
        int           w;
        it = t_stream_item'(66'({$urandom, $urandom, $urandom}));
        it.sample_real = random_sample();
        it.sample_imag = random_sample();
        if ($urandom_range(0, 9) < 8) begin
            it.time_index = 5'($urandom_range(0, sb.rows_in_use()));
            it.freq_index = 7'($urandom_range(0, sb.cols_in_use()));
        end
        if ($urandom_range(0, 9) == 0)
            it.tap_value = $urandom_range(0, 1) ? '1 : '0;
        w = $urandom_range(0, 99);
        if (w < 8)       it.op = OP_LOAD;
        else if (w < 50) it.op = OP_ADD;
        else if (w < 54) it.op = OP_FRAME;
        else             it.op = OP_READ;
        return it;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                feed_steady = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            send_item(random_item());
        end
    endtask

    task automatic load_all_taps(input bit full_scale);
        for (int r = 0; r < N_TAP_ROWS; r++)
            for (int c = 0; c < N_TAP_COLS; c++)
                send_item(make_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom, r, c,
                                    full_scale ? 32767 : ((r + c == 0) ? 0 : $urandom)));
    endtask

    // all adds land on cell (5, 41), which is driven into both rails
    task automatic run_pileup(input int count);
        t_stream_item it;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                feed_steady = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            it = t_stream_item'(66'({$urandom, $urandom, $urandom}));
            if ($urandom_range(0, 99) < 92) begin
                it.op          = OP_ADD;
                it.time_index  = 5'(2 + $urandom_range(0, 1));
                it.freq_index  = 7'(40 + $urandom_range(0, 1));
                it.sample_real = ($urandom_range(0, 99) < 97) ? 16'h7FFF : random_sample();
                it.sample_imag = ($urandom_range(0, 99) < 97) ? 16'h8000 : random_sample();
            end else begin
                it.op = OP_READ;
                if ($urandom_range(0, 1)) begin
                    it.time_index = 5'd5;
                    it.freq_index = 7'd41;
                end else begin
                    it.time_index = 5'($urandom_range(2, 6));
                    it.freq_index = 7'($urandom_range(36, 45));
                end
            end
            send_item(it);
        end
        send_item(make_item(OP_READ, 0, 0, 5, 41, 0, 0, 0));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small odd-width kernel on a 5 x 20 grid
        configure(2, 3, 3, 20);
        send_item(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 32767));
        send_item(make_item(OP_LOAD, 0, 0, 0, 0, 0, 1, 16384));
        send_item(make_item(OP_LOAD, 0, 0, 0, 0, 0, 2, 1));
        send_item(make_item(OP_LOAD, 0, 0, 0, 0, 1, 0, 0));
        send_item(make_item(OP_LOAD, 0, 0, 0, 0, 1, 1, 32767));
        send_item(make_item(OP_LOAD, 0, 0, 0, 0, 1, 2, 12345));
        send_item(make_item(OP_ADD, 32767, -32768, 0, 10, 3, 7, 32767));
        send_item(make_item(OP_ADD, -32768, 32767, 1, 10, 0, 0, 0));
        send_item(make_item(OP_ADD, -1, 1, 0, 0, 0, 0, 0));
        send_item(make_item(OP_ADD, 1000, -1000, 4, 19, 0, 0, 0));
        send_item(make_item(OP_ADD, 5, 5, 31, 127, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 10, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 1, 9, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 1, 11, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 4, 19, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 5, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 20, 0, 0, 0));
        send_item(make_item(OP_READ, -1, -1, 31, 127, 3, 7, 32767));
        send_item(make_item(OP_FRAME, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 1, 18, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 10, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 2, 10, 0, 0, 0));
        settle();

        configure(4, 8, 16, 128);
        load_all_taps(1'b0);
        run_random(130);
        settle();

        configure(0, 0, 0, 0);
        run_random(30);
        settle();

        configure(7, 15, 31, 255);
        run_random(60);
        settle();

        configure(1, 1, 1, 1);
        run_random(40);
        settle();

        configure(3, 5, 7, 50);
        run_random(60);
        settle();

        configure(4, 8, 16, 128);
        load_all_taps(1'b1);
        run_pileup(330);
        settle();

        $display("Run covered %0d tap loads, %0d adds, %0d frame resets and %0d reads",
                 sb.n_loads, sb.n_adds, sb.n_frames, sb.n_reads);
        $display("over six register settings; %0d reads hit a saturated cell, %0d errors.",
                 sb.n_sat, sb.errors);
        if (sb.errors == 0 && sb.pending_cells.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $error("timeout: run did not complete");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
